>>> rtl/core/dsuf_pkg.sv
package dsuf_pkg;

  localparam int ELEM_W   = 8;
  localparam int RANK_W   = 4;
  localparam int STATUS_W = 2;
  localparam int OP_W     = 2;

  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_JOINED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_MADE = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_MAKE  = 2'd0,
    OP_FIND  = 2'd1,
    OP_UNION = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_CMP,
    S_CMP_WR,
    S_LINK,
    S_BUMP,
    S_RESP
  } state_t;

endpackage

>>> rtl/core/dsuf_ram.sv
module dsuf_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rd_data_r <= mem[addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/disjoint_set_union_find.sv
// Channel | Dir | tdata                         | tuser
// in_     | in  | [7:0] elem_a, [15:8] elem_b   | [1:0] op
// out_    | out | [7:0] root                    | [1:0] status
//
// One item at a time; every memory access goes through one single-port RAM
// holding {rank, parent} per element; read data arrives in the cycle after the
// address. Make set and error items go from acceptance straight to the result.
// A find steps through accept, walk reads up to the root, one read and one
// write per node rewritten, a last check and the result. A union walks both
// sides, links distinct roots, and on a rank tie below the maximum bumps the rank.
// Valid marks are flip-flops cleared by rst_n; the RAM needs no clearing.
// A finished result waits in the output register; the next item is taken
// meanwhile, and the block stalls only when a second result is ready.
module disjoint_set_union_find #(
  parameter int ELEMENTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] elem_a, [15:8] elem_b
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] root
  output logic [1:0]  out_tuser   // [1:0] status
);

  // Indices are 8 bits, so at most 256 entries can ever be reached.
  localparam int DEPTH = (ELEMENTS < 256) ? ELEMENTS : 256;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WW    = dsuf_pkg::RANK_W + AW;

  dsuf_pkg::state_t state_r, state_nxt;

  logic [DEPTH-1:0] valid_r;
  dsuf_pkg::op_t    op_r, op_nxt;
  logic [AW-1:0]    b_r, b_nxt;
  logic [AW-1:0]    node_r, node_nxt;
  logic [AW-1:0]    start_r, start_nxt;
  logic [AW-1:0]    cur_r, cur_nxt;
  logic [AW-1:0]    top_r, top_nxt;
  logic [dsuf_pkg::RANK_W-1:0] top_rank_r, top_rank_nxt;
  logic             second_r, second_nxt;
  logic [AW-1:0]    ra_r, ra_nxt;
  logic [dsuf_pkg::RANK_W-1:0] ra_rank_r, ra_rank_nxt;
  logic [AW-1:0]    winner_r, winner_nxt;
  logic [AW-1:0]    loser_r, loser_nxt;
  logic [dsuf_pkg::RANK_W-1:0] loser_rank_r, loser_rank_nxt;
  logic [dsuf_pkg::RANK_W-1:0] win_rank_r, win_rank_nxt;
  logic             bump_r, bump_nxt;
  logic [dsuf_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [dsuf_pkg::ELEM_W-1:0]   res_root_r, res_root_nxt;
  logic [dsuf_pkg::STATUS_W-1:0] out_status_r;
  logic [dsuf_pkg::ELEM_W-1:0]   out_root_r;
  logic             out_valid_r;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [WW-1:0] mem_wdata;
  logic [WW-1:0] rd_data;
  logic [AW-1:0] rd_par;
  logic [dsuf_pkg::RANK_W-1:0] rd_rank;

  logic          in_fire;
  logic          out_free;
  logic          out_load;
  logic          valid_set;
  logic [AW-1:0] a_idx;
  logic [AW-1:0] b_idx;
  logic          a_in_range;
  logic          b_in_range;
  logic          a_usable;
  logic          b_usable;
  dsuf_pkg::op_t in_op;

  assign in_tready = (state_r == dsuf_pkg::S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign out_load  = (state_r == dsuf_pkg::S_RESP) && out_free;

  assign in_op      = dsuf_pkg::op_t'(in_tuser);
  assign a_in_range = (32'(in_tdata[7:0]) < 32'(DEPTH));
  assign b_in_range = (32'(in_tdata[15:8]) < 32'(DEPTH));
  assign a_idx      = AW'(in_tdata[7:0]);
  assign b_idx      = AW'(in_tdata[15:8]);
  assign a_usable   = a_in_range && valid_r[a_idx];
  assign b_usable   = b_in_range && valid_r[b_idx];

  assign rd_par  = rd_data[AW-1:0];
  assign rd_rank = rd_data[WW-1:AW];

  dsuf_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .addr    (mem_addr),
    .wdata   (mem_wdata),
    .rd_data (rd_data)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dsuf_pkg::S_IDLE: begin
        if (in_fire) begin
          if ((in_op == dsuf_pkg::OP_FIND && a_usable) ||
              (in_op == dsuf_pkg::OP_UNION && a_usable && b_usable)) begin
            state_nxt = dsuf_pkg::S_WALK;
          end else begin
            state_nxt = dsuf_pkg::S_RESP;
          end
        end
      end
      dsuf_pkg::S_WALK: begin
        if (rd_par == node_r) begin
          state_nxt = dsuf_pkg::S_CMP;
        end
      end
      dsuf_pkg::S_CMP: begin
        if (cur_r != top_r) begin
          state_nxt = dsuf_pkg::S_CMP_WR;
        end else if (op_r == dsuf_pkg::OP_FIND) begin
          state_nxt = dsuf_pkg::S_RESP;
        end else if (!second_r) begin
          state_nxt = dsuf_pkg::S_WALK;
        end else if (top_r == ra_r) begin
          state_nxt = dsuf_pkg::S_RESP;
        end else begin
          state_nxt = dsuf_pkg::S_LINK;
        end
      end
      dsuf_pkg::S_CMP_WR: state_nxt = dsuf_pkg::S_CMP;
      dsuf_pkg::S_LINK: begin
        state_nxt = bump_r ? dsuf_pkg::S_BUMP : dsuf_pkg::S_RESP;
      end
      dsuf_pkg::S_BUMP: state_nxt = dsuf_pkg::S_RESP;
      dsuf_pkg::S_RESP: begin
        if (out_free) begin
          state_nxt = dsuf_pkg::S_IDLE;
        end
      end
      default: state_nxt = dsuf_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    mem_we         = 1'b0;
    mem_addr       = node_r;
    mem_wdata      = '0;
    valid_set      = 1'b0;
    op_nxt         = op_r;
    b_nxt          = b_r;
    node_nxt       = node_r;
    start_nxt      = start_r;
    cur_nxt        = cur_r;
    top_nxt        = top_r;
    top_rank_nxt   = top_rank_r;
    second_nxt     = second_r;
    ra_nxt         = ra_r;
    ra_rank_nxt    = ra_rank_r;
    winner_nxt     = winner_r;
    loser_nxt      = loser_r;
    loser_rank_nxt = loser_rank_r;
    win_rank_nxt   = win_rank_r;
    bump_nxt       = bump_r;
    res_status_nxt = res_status_r;
    res_root_nxt   = res_root_r;
    case (state_r)
      dsuf_pkg::S_IDLE: begin
        if (in_fire) begin
          op_nxt         = in_op;
          b_nxt          = b_idx;
          node_nxt       = a_idx;
          start_nxt      = a_idx;
          second_nxt     = 1'b0;
          mem_addr       = a_idx;
          res_status_nxt = dsuf_pkg::ST_NOT_MADE;
          res_root_nxt   = '0;
          case (in_op)
            dsuf_pkg::OP_MAKE: begin
              if (a_in_range) begin
                mem_we         = 1'b1;
                mem_wdata      = {{dsuf_pkg::RANK_W{1'b0}}, a_idx};
                valid_set      = 1'b1;
                res_status_nxt = dsuf_pkg::ST_DONE;
                res_root_nxt   = in_tdata[7:0];
              end
            end
            dsuf_pkg::OP_FIND, dsuf_pkg::OP_UNION: begin
            end
            default: res_status_nxt = dsuf_pkg::ST_DONE;
          endcase
        end
      end
      dsuf_pkg::S_WALK: begin
        if (rd_par != node_r) begin
          mem_addr = rd_par;
          node_nxt = rd_par;
        end else begin
          top_nxt      = node_r;
          top_rank_nxt = rd_rank;
          cur_nxt      = start_r;
        end
      end
      dsuf_pkg::S_CMP: begin
        mem_addr = cur_r;
        if (cur_r == top_r) begin
          if (op_r == dsuf_pkg::OP_FIND) begin
            res_status_nxt = dsuf_pkg::ST_DONE;
            res_root_nxt   = 8'(top_r);
          end else if (!second_r) begin
            // first root known; walk from the second element
            ra_nxt      = top_r;
            ra_rank_nxt = top_rank_r;
            second_nxt  = 1'b1;
            mem_addr    = b_r;
            node_nxt    = b_r;
            start_nxt   = b_r;
          end else if (top_r == ra_r) begin
            res_status_nxt = dsuf_pkg::ST_JOINED;
            res_root_nxt   = 8'(ra_r);
          end else if (ra_rank_r >= top_rank_r) begin
            winner_nxt     = ra_r;
            loser_nxt      = top_r;
            loser_rank_nxt = top_rank_r;
            win_rank_nxt   = ra_rank_r;
            bump_nxt       = (ra_rank_r == top_rank_r) && (ra_rank_r != dsuf_pkg::RANK_MAX);
            res_status_nxt = dsuf_pkg::ST_DONE;
            res_root_nxt   = 8'(ra_r);
          end else begin
            winner_nxt     = top_r;
            loser_nxt      = ra_r;
            loser_rank_nxt = ra_rank_r;
            win_rank_nxt   = top_rank_r;
            bump_nxt       = 1'b0;
            res_status_nxt = dsuf_pkg::ST_DONE;
            res_root_nxt   = 8'(top_r);
          end
        end
      end
      dsuf_pkg::S_CMP_WR: begin
        // point the node straight at the root, keep its rank
        mem_we    = 1'b1;
        mem_addr  = cur_r;
        mem_wdata = {rd_rank, top_r};
        cur_nxt   = rd_par;
      end
      dsuf_pkg::S_LINK: begin
        mem_we    = 1'b1;
        mem_addr  = loser_r;
        mem_wdata = {loser_rank_r, winner_r};
      end
      dsuf_pkg::S_BUMP: begin
        mem_we    = 1'b1;
        mem_addr  = winner_r;
        mem_wdata = {win_rank_r + 1'b1, winner_r};
      end
      dsuf_pkg::S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dsuf_pkg::S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_load || (out_valid_r && !out_tready);
      if (valid_set) begin
        valid_r[a_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    b_r          <= b_nxt;
    node_r       <= node_nxt;
    start_r      <= start_nxt;
    cur_r        <= cur_nxt;
    top_r        <= top_nxt;
    top_rank_r   <= top_rank_nxt;
    second_r     <= second_nxt;
    ra_r         <= ra_nxt;
    ra_rank_r    <= ra_rank_nxt;
    winner_r     <= winner_nxt;
    loser_r      <= loser_nxt;
    loser_rank_r <= loser_rank_nxt;
    win_rank_r   <= win_rank_nxt;
    bump_r       <= bump_nxt;
    res_status_r <= res_status_nxt;
    res_root_r   <= res_root_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_root_r   <= res_root_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_root_r;
  assign out_tuser  = out_status_r;

`ifndef NO_ASSERTIONS
  a_fire_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != dsuf_pkg::S_IDLE))
    else $error("accepted transaction left block idle");

  a_resp_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && state_r == dsuf_pkg::S_IDLE))
    else $error("result not loaded into output register");

  a_no_root_rewrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dsuf_pkg::S_CMP_WR) |-> (cur_r != top_r))
    else $error("compression rewrote the root");

  a_link_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dsuf_pkg::S_LINK) |-> (loser_r != winner_r))
    else $error("union linked a root under itself");
`endif

endmodule

>>> tb/sv/tb_disjoint_set_union_find.sv
`timescale 1ns / 100ps

module tb_disjoint_set_union_find;

  localparam logic [dsuf_pkg::OP_W-1:0] OP_SPARE = 2'd3;  // unused code, must be a no-op
  localparam int RANDOM_ITEMS = 1680;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int N_DIRECTED   = 25;

  typedef struct packed {
    logic [dsuf_pkg::STATUS_W-1:0] status;
    logic [dsuf_pkg::ELEM_W-1:0]   root;
  } dsu_reply_t;

  typedef struct packed {
    logic [dsuf_pkg::OP_W-1:0]     op;
    logic [dsuf_pkg::ELEM_W-1:0]   a;
    logic [dsuf_pkg::ELEM_W-1:0]   b;
    logic                          typed;
    logic [dsuf_pkg::STATUS_W-1:0] st;
    logic [dsuf_pkg::ELEM_W-1:0]   root;
  } dsu_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [7:0] elem_a, [15:8] elem_b
  logic [1:0]  in_tuser;   // [1:0] op
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] root
  logic [1:0]  out_tuser;  // [1:0] status

  // Shadow copy of the disjoint-set table
  logic [dsuf_pkg::ELEM_W-1:0] parent_of [256];
  logic [dsuf_pkg::RANK_W-1:0] rank_of   [256];
  bit                          made      [256];

  dsu_reply_t awaited_replies [$];

  int send_idle_pct = 37;
  int recv_idle_pct = 56;
  bit hold_req = 1'b0;
  int items_sent = 0;
  int mismatches = 0;
  int seen_done = 0;
  int seen_joined = 0;
  int seen_not_made = 0;
  int quiet_cycles = 0;

  dsu_row_t directed_plan [N_DIRECTED] = '{
    '{dsuf_pkg::OP_FIND,  8'd0,   8'd0,   1'b1, dsuf_pkg::ST_NOT_MADE, 8'd0},
    '{dsuf_pkg::OP_UNION, 8'd255, 8'd0,   1'b1, dsuf_pkg::ST_NOT_MADE, 8'd0},
    '{OP_SPARE,           8'd255, 8'd255, 1'b1, dsuf_pkg::ST_DONE,     8'd0},
    '{dsuf_pkg::OP_MAKE,  8'd0,   8'd0,   1'b1, dsuf_pkg::ST_DONE,     8'd0},
    '{dsuf_pkg::OP_MAKE,  8'd255, 8'd0,   1'b1, dsuf_pkg::ST_DONE,     8'd255},
    '{dsuf_pkg::OP_UNION, 8'd0,   8'd255, 1'b1, dsuf_pkg::ST_DONE,     8'd0},
    '{dsuf_pkg::OP_FIND,  8'd255, 8'd0,   1'b1, dsuf_pkg::ST_DONE,     8'd0},
    '{dsuf_pkg::OP_UNION, 8'd255, 8'd0,   1'b1, dsuf_pkg::ST_JOINED,   8'd0},
    '{dsuf_pkg::OP_UNION, 8'd0,   8'd128, 1'b1, dsuf_pkg::ST_NOT_MADE, 8'd0},
    '{dsuf_pkg::OP_MAKE,  8'd128, 8'd255, 1'b1, dsuf_pkg::ST_DONE,     8'd128},
    '{dsuf_pkg::OP_UNION, 8'd128, 8'd0,   1'b0, dsuf_pkg::ST_DONE,     8'd0},
    '{dsuf_pkg::OP_MAKE,  8'd1,   8'd0,   1'b1, dsuf_pkg::ST_DONE,     8'd1},
    '{dsuf_pkg::OP_MAKE,  8'd2,   8'd0,   1'b1, dsuf_pkg::ST_DONE,     8'd2},
    '{dsuf_pkg::OP_UNION, 8'd2,   8'd1,   1'b0, dsuf_pkg::ST_DONE,     8'd0},
    '{dsuf_pkg::OP_MAKE,  8'd3,   8'd0,   1'b1, dsuf_pkg::ST_DONE,     8'd3},
    '{dsuf_pkg::OP_MAKE,  8'd4,   8'd0,   1'b1, dsuf_pkg::ST_DONE,     8'd4},
    '{dsuf_pkg::OP_UNION, 8'd3,   8'd4,   1'b0, dsuf_pkg::ST_DONE,     8'd0},
    '{dsuf_pkg::OP_UNION, 8'd1,   8'd3,   1'b0, dsuf_pkg::ST_DONE,     8'd0},
    '{dsuf_pkg::OP_UNION, 8'd0,   8'd4,   1'b0, dsuf_pkg::ST_DONE,     8'd0},
    '{dsuf_pkg::OP_FIND,  8'd255, 8'd0,   1'b0, dsuf_pkg::ST_DONE,     8'd0},
    '{dsuf_pkg::OP_MAKE,  8'd0,   8'd0,   1'b1, dsuf_pkg::ST_DONE,     8'd0},
    '{dsuf_pkg::OP_FIND,  8'd128, 8'd0,   1'b0, dsuf_pkg::ST_DONE,     8'd0},
    '{dsuf_pkg::OP_FIND,  8'd4,   8'd0,   1'b0, dsuf_pkg::ST_DONE,     8'd0},
    '{dsuf_pkg::OP_UNION, 8'hAA,  8'h55,  1'b1, dsuf_pkg::ST_NOT_MADE, 8'd0},
    '{OP_SPARE,           8'h55,  8'hAA,  1'b1, dsuf_pkg::ST_DONE,     8'd0}
  };

  disjoint_set_union_find #(
    .ELEMENTS(256)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Walk to the root, then point every node on the path straight at it
  function automatic logic [dsuf_pkg::ELEM_W-1:0] climb_and_flatten(
      logic [dsuf_pkg::ELEM_W-1:0] e);
    logic [dsuf_pkg::ELEM_W-1:0] top;
    logic [dsuf_pkg::ELEM_W-1:0] cur;
    logic [dsuf_pkg::ELEM_W-1:0] nxt;
    int steps;
    top = e;
    steps = 0;
    while (parent_of[top] != top && steps < 256) begin
      top = parent_of[top];
      steps++;
    end
    cur = e;
    while (cur != top) begin
      nxt = parent_of[cur];
      parent_of[cur] = top;
      cur = nxt;
    end
    return top;
  endfunction

  function automatic dsu_reply_t resolve_dsu_op(logic [dsuf_pkg::OP_W-1:0] op,
                                                logic [dsuf_pkg::ELEM_W-1:0] a,
                                                logic [dsuf_pkg::ELEM_W-1:0] b);
    dsu_reply_t r;
    logic [dsuf_pkg::ELEM_W-1:0] ra;
    logic [dsuf_pkg::ELEM_W-1:0] rb;
    r.status = dsuf_pkg::ST_DONE;
    r.root = '0;
    case (op)
      dsuf_pkg::OP_MAKE: begin
        parent_of[a] = a;
        rank_of[a] = '0;
        made[a] = 1'b1;
        r.root = a;
      end
      dsuf_pkg::OP_FIND: begin
        if (made[a]) r.root = climb_and_flatten(a);
        else r.status = dsuf_pkg::ST_NOT_MADE;
      end
      dsuf_pkg::OP_UNION: begin
        if (made[a] && made[b]) begin
          ra = climb_and_flatten(a);
          rb = climb_and_flatten(b);
          if (ra == rb) begin
            r.status = dsuf_pkg::ST_JOINED;
            r.root = ra;
          end else if (rank_of[ra] >= rank_of[rb]) begin
            // tie: second root goes under the first, first rank rises (saturating)
            if (rank_of[ra] == rank_of[rb] && rank_of[ra] != dsuf_pkg::RANK_MAX)
              rank_of[ra] = rank_of[ra] + 1'b1;
            parent_of[rb] = ra;
            r.root = ra;
          end else begin
            parent_of[ra] = rb;
            r.root = rb;
          end
        end else begin
          r.status = dsuf_pkg::ST_NOT_MADE;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [dsuf_pkg::ELEM_W-1:0] pick_made_elem();
    logic [dsuf_pkg::ELEM_W-1:0] e;
    e = 8'($urandom_range(255));
    repeat (64) begin
      if (made[e]) return e;
      e = 8'($urandom_range(255));
    end
    return e;
  endfunction

  // Offer one item and hold it until the block takes it; predict on acceptance
  task automatic send_item(input logic [dsuf_pkg::OP_W-1:0] op,
                           input logic [dsuf_pkg::ELEM_W-1:0] a,
                           input logic [dsuf_pkg::ELEM_W-1:0] b, input logic typed,
                           input dsu_reply_t want);
    dsu_reply_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = resolve_dsu_op(op, a, b);
    awaited_replies.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic drain_replies();
    in_tvalid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_item();
    int roll;
    logic [dsuf_pkg::OP_W-1:0] op;
    logic [dsuf_pkg::ELEM_W-1:0] a;
    logic [dsuf_pkg::ELEM_W-1:0] b;
    roll = $urandom_range(99);
    if (roll < 8) begin
      // noise: any op code, any indices
      op = 2'($urandom_range(3));
      a = 8'($urandom_range(255));
      b = 8'($urandom_range(255));
    end else if (roll < 22) begin
      op = dsuf_pkg::OP_MAKE;
      a = 8'($urandom_range(255));
      b = 8'($urandom_range(255));
    end else if (roll < 55) begin
      op = dsuf_pkg::OP_FIND;
      a = pick_made_elem();
      b = 8'($urandom_range(255));
    end else begin
      op = dsuf_pkg::OP_UNION;
      a = pick_made_elem();
      b = pick_made_elem();
    end
    send_item(op, a, b, 1'b0, '0);
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    dsu_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_replies.size() == 0) begin
        $error("result with nothing pending: status %0d root %0d", out_tuser, out_tdata);
        mismatches++;
      end else begin
        want = awaited_replies.pop_front();
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_tuser);
          mismatches++;
        end
        if (out_tdata !== want.root) begin
          $error("root: expected %0d, actual %0d", want.root, out_tdata);
          mismatches++;
        end
        case (want.status)
          dsuf_pkg::ST_DONE:   seen_done++;
          dsuf_pkg::ST_JOINED: seen_joined++;
          default:             seen_not_made++;
        endcase
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_plan[i])
      send_item(directed_plan[i].op, directed_plan[i].a, directed_plan[i].b,
                directed_plan[i].typed, {directed_plan[i].st, directed_plan[i].root});

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        drain_replies();
        send_idle_pct = 56;
        recv_idle_pct = 37;
        // fill the block while results back up
        hold_req = 1'b1;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        drain_replies();
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_random_item();
    end

    drain_replies();
    repeat (100) @(posedge clk);

    $display("Summary: %0d items (directed and random ops, errors, no-op code) sent",
             items_sent);
    $display("Summary: results done %0d, joined %0d, not made %0d; %0d mismatches",
             seen_done, seen_joined, seen_not_made, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
